>>> src/wfcf_pkg.sv
// shared types and constants for the frame capture filter
// no dependencies; imported by wfcf_sec_div and wifi_frame_capture_filter
`default_nettype none

package wfcf_pkg;

    // field widths
    localparam int unsigned FC_W       = 8;
    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned LEN_W      = 12;
    localparam int unsigned TS_W       = 63;
    localparam int unsigned SEC_W      = 32;
    localparam int unsigned MICROS_W   = 20;
    localparam int unsigned FLAGS_W    = 3;
    localparam int unsigned TIME_W     = 64;

    // stream and configuration port widths
    localparam int unsigned S_TDATA_W  = 232;
    localparam int unsigned M_TDATA_W  = 80;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    // seconds divider: ts / 1000000 == (ts >> 6) / 15625
    localparam int unsigned LOW_W      = 6;
    localparam int unsigned X_W        = TS_W - LOW_W;
    localparam int unsigned CHUNK_W    = 19;
    localparam int unsigned NUM_CHUNKS = X_W / CHUNK_W;
    localparam int unsigned REM_W      = 14;
    localparam int unsigned DIVD_W     = REM_W + CHUNK_W;
    localparam int unsigned RECIP_W    = 33;
    localparam int unsigned RECIP_SHIFT = 46;
    localparam int unsigned DIV_ODD    = 15625;
    localparam logic [RECIP_W-1:0] RECIP_M = 33'd4503599627;

    localparam logic [TIME_W-1:0] BEACON_INTERVAL_US = 64'd5000000;
    localparam logic [LEN_W-1:0]  MAX_CAPTURE        = 12'd2048;
    localparam logic [MICROS_W-1:0] US_PER_SECOND    = 20'd1000000;

    // frame control decode
    localparam logic [1:0] FT_MGMT        = 2'd0;
    localparam logic [1:0] FT_CTRL        = 2'd1;
    localparam logic [3:0] SUBTYPE_BEACON = 4'd8;

    // capture_flags bits
    localparam int unsigned FLAG_FULL_DATA = 0;
    localparam int unsigned FLAG_THROTTLE  = 1;
    localparam int unsigned FLAG_FILTER    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPTURE_FLAGS   = 3'd0,
        CFG_FILTER_ADDRESS  = 3'd1,
        CFG_SMALL_DATA_SNAP = 3'd2,
        CFG_MGMT_CTRL_SNAP  = 3'd3,
        CFG_LARGE_THRESHOLD = 3'd4,
        CFG_LARGE_DATA_SNAP = 3'd5,
        CFG_SECONDS_OFFSET  = 3'd6
    } cfg_idx_t;

    // record fields carried alongside the divider
    typedef struct packed {
        logic [LOW_W-1:0] low6;
        logic [LEN_W-1:0] capt;
        logic [LEN_W-1:0] orig;
    } side_t;

endpackage

`default_nettype wire

>>> src/wifi_frame_capture_filter.sv
// Capture filter for received 802.11 frame headers. One header is taken per
// clock; a kept frame gives one record header after passing the input
// register, six divider stages and the output register, a dropped one gives
// nothing. The rate of one frame per cycle is held as long as records are
// taken; a three-chunk reciprocal divider splits the timestamp into seconds
// and microseconds. Beacon throttling is decided as a frame leaves the input
// register, so back-to-back beacons see each other.
// Depends on wfcf_pkg and wfcf_sec_div.
`default_nettype none

module wifi_frame_capture_filter (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // s_tdata: frame_control[7:0], address_one[55:8], address_two[103:56],
    // address_three[151:104], frame_length[163:152], timestamp_us[226:164]
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [wfcf_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: record_seconds[31:0], record_micros[51:32],
    // captured_length[63:52], original_length[75:64]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [wfcf_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wfcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wfcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wfcf_pkg::*;

    // configuration
    logic [FLAGS_W-1:0] flags_reg;
    logic [ADDR_W-1:0]  faddr_reg;
    logic [LEN_W-1:0]   small_snap_reg;
    logic [LEN_W-1:0]   mgmt_snap_reg;
    logic [LEN_W-1:0]   thresh_reg;
    logic [LEN_W-1:0]   large_snap_reg;
    logic [SEC_W-1:0]   sec_off_reg;

    // input register
    logic               in_vld_reg;
    logic [FC_W-1:0]    fc_reg;
    logic [ADDR_W-1:0]  a1_reg;
    logic [ADDR_W-1:0]  a2_reg;
    logic [ADDR_W-1:0]  a3_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [TS_W-1:0]    ts_reg;

    logic [TIME_W-1:0]  nbt_reg;
    logic [TIME_W-1:0]  nbt_next;

    // output register
    logic               out_vld_reg;
    logic [SEC_W-1:0]   out_sec_reg;
    logic [MICROS_W-1:0] out_us_reg;
    logic [LEN_W-1:0]   out_capt_reg;
    logic [LEN_W-1:0]   out_orig_reg;

    logic [1:0]         ftype;
    logic [3:0]         fsub;
    logic               addr_hit;
    logic               is_beacon;
    logic               throttle_chk;
    logic               too_soon;
    logic               keep;
    logic               in_move;
    logic [LEN_W-1:0]   snap;
    logic [LEN_W-1:0]   snap_max;
    logic [LEN_W-1:0]   snap_clamp;
    side_t              div_side_in;
    logic               div_in_ready;
    logic               div_out_valid;
    logic               div_out_ready;
    logic [SEC_W-1:0]   div_quot;
    logic [REM_W-1:0]   div_rem;
    side_t              div_side_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg      <= 3'd2;
            faddr_reg      <= '0;
            small_snap_reg <= 12'd256;
            mgmt_snap_reg  <= 12'd1024;
            thresh_reg     <= 12'd256;
            large_snap_reg <= 12'd128;
            sec_off_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CAPTURE_FLAGS:   flags_reg      <= cfg_data[FLAGS_W-1:0];
                CFG_FILTER_ADDRESS:  faddr_reg      <= cfg_data[ADDR_W-1:0];
                CFG_SMALL_DATA_SNAP: small_snap_reg <= cfg_data[LEN_W-1:0];
                CFG_MGMT_CTRL_SNAP:  mgmt_snap_reg  <= cfg_data[LEN_W-1:0];
                CFG_LARGE_THRESHOLD: thresh_reg     <= cfg_data[LEN_W-1:0];
                CFG_LARGE_DATA_SNAP: large_snap_reg <= cfg_data[LEN_W-1:0];
                CFG_SECONDS_OFFSET:  sec_off_reg    <= cfg_data[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // filter decision on the registered header
    assign ftype        = fc_reg[3:2];
    assign fsub         = fc_reg[7:4];
    assign addr_hit     = (a1_reg == faddr_reg) || (a2_reg == faddr_reg) ||
                          (a3_reg == faddr_reg);
    assign is_beacon    = (ftype == FT_MGMT) && (fsub == SUBTYPE_BEACON);
    assign throttle_chk = flags_reg[FLAG_FILTER] && addr_hit &&
                          flags_reg[FLAG_THROTTLE] && is_beacon;
    assign too_soon     = nbt_reg > {1'b0, ts_reg};
    assign keep         = !flags_reg[FLAG_FILTER] || (addr_hit && !(throttle_chk && too_soon));

    // dropped frames leave without waiting on the divider
    assign in_move  = in_vld_reg && (div_in_ready || !keep);
    assign s_tready = !in_vld_reg || in_move;

    always_comb
    begin
        nbt_next = nbt_reg;
        if (in_move && throttle_chk && !too_soon)
        begin
            nbt_next = {1'b0, ts_reg} + BEACON_INTERVAL_US;
        end
    end

    always_comb
    begin
        if ((ftype == FT_MGMT) || (ftype == FT_CTRL))
        begin
            snap = mgmt_snap_reg;
        end
        else if (flags_reg[FLAG_FULL_DATA])
        begin
            snap = len_reg;
        end
        else if (len_reg >= thresh_reg)
        begin
            snap = large_snap_reg;
        end
        else
        begin
            snap = small_snap_reg;
        end
    end

    assign snap_max   = (snap > MAX_CAPTURE) ? MAX_CAPTURE : snap;
    assign snap_clamp = (snap_max > len_reg) ? len_reg : snap_max;

    assign div_side_in.low6 = ts_reg[LOW_W-1:0];
    assign div_side_in.capt = snap_clamp;
    assign div_side_in.orig = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            nbt_reg    <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            nbt_reg <= nbt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            fc_reg  <= s_tdata[7:0];
            a1_reg  <= s_tdata[55:8];
            a2_reg  <= s_tdata[103:56];
            a3_reg  <= s_tdata[151:104];
            len_reg <= s_tdata[163:152];
            ts_reg  <= s_tdata[226:164];
        end
    end

    wfcf_sec_div u_sec_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_vld_reg && keep),
        .in_ready  (div_in_ready),
        .in_x      (ts_reg[TS_W-1:LOW_W]),
        .in_side   (div_side_in),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_quot  (div_quot),
        .out_rem   (div_rem),
        .out_side  (div_side_out)
    );

    assign div_out_ready = !out_vld_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (div_out_ready)
        begin
            out_vld_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_out_ready && div_out_valid)
        begin
            out_sec_reg  <= div_quot + sec_off_reg;
            out_us_reg   <= {div_rem, div_side_out.low6};
            out_capt_reg <= div_side_out.capt;
            out_orig_reg <= div_side_out.orig;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0, out_orig_reg, out_capt_reg, out_us_reg, out_sec_reg};

    a_micros_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_us_reg < US_PER_SECOND)
        else $error("record microseconds out of range");

    a_capt_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_capt_reg <= out_orig_reg) && (out_capt_reg <= MAX_CAPTURE))
        else $error("captured length exceeds its limits");

    a_beacon_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_move |=> nbt_reg == $past(nbt_reg))
        else $error("next beacon time moved without a frame leaving");

    a_rate: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input refused while the output is empty");

endmodule

`default_nettype wire

>>> src/wfcf_sec_div.sv
// pipelined divide of (timestamp >> 6) by 15625, three chunks of 19 bits
// each chunk: reciprocal multiply stage, then back-multiply and correct stage
// depends on wfcf_pkg
`default_nettype none

module wfcf_sec_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [wfcf_pkg::X_W-1:0]   in_x,
    input  wire wfcf_pkg::side_t            in_side,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [wfcf_pkg::SEC_W-1:0]      out_quot,
    output logic [wfcf_pkg::REM_W-1:0]      out_rem,
    output wfcf_pkg::side_t                 out_side
);
    import wfcf_pkg::*;

    localparam int unsigned STAGES = 2 * NUM_CHUNKS;

    typedef struct packed {
        logic [X_W-1:0]     x;
        logic [DIVD_W-1:0]  divd;
        logic [CHUNK_W-1:0] qe;
        logic [REM_W-1:0]   rem;
        logic [SEC_W-1:0]   quot;
        side_t              side;
    } stage_t;

    stage_t             src_w    [STAGES];
    stage_t             stg_next [STAGES];
    stage_t             stg_reg  [STAGES];
    logic [STAGES-1:0]  vld_reg;
    logic [STAGES-1:0]  vin;
    logic [STAGES-1:0]  rdy;

    always_comb
    begin
        src_w[0]      = '0;
        src_w[0].x    = in_x;
        src_w[0].side = in_side;
    end

    assign vin[0] = in_valid;

    genvar i;
    generate
        for (i = 1; i < STAGES; i++)
        begin : g_link
            assign src_w[i] = stg_reg[i-1];
            assign vin[i]   = vld_reg[i-1];
        end

        for (i = 0; i < STAGES; i++)
        begin : g_ctrl
            if (i == STAGES - 1)
            begin : g_last
                assign rdy[i] = !vld_reg[i] || out_ready;
            end
            else
            begin : g_mid
                assign rdy[i] = !vld_reg[i] || rdy[i+1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (rdy[i])
                begin
                    vld_reg[i] <= vin[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[i] && vin[i])
                begin
                    stg_reg[i] <= stg_next[i];
                end
            end
        end
    endgenerate

    genvar k;
    generate
        for (k = 0; k < NUM_CHUNKS; k++)
        begin : g_chunk
            logic [DIVD_W-1:0]         a_divd;
            logic [DIVD_W+RECIP_W-1:0] a_prod;
            logic [DIVD_W-1:0]         b_prod;
            logic [DIVD_W-1:0]         b_diff;
            logic                      b_fix;
            logic [CHUNK_W-1:0]        b_q;

            // estimate is the true quotient or one below it
            assign a_divd = {src_w[2*k].rem, src_w[2*k].x[X_W-1-CHUNK_W*k -: CHUNK_W]};
            assign a_prod = a_divd * RECIP_M;

            always_comb
            begin
                stg_next[2*k]      = src_w[2*k];
                stg_next[2*k].divd = a_divd;
                stg_next[2*k].qe   = a_prod[RECIP_SHIFT +: CHUNK_W];
            end

            assign b_prod = DIVD_W'(src_w[2*k+1].qe) * DIVD_W'(DIV_ODD);
            assign b_diff = src_w[2*k+1].divd - b_prod;
            assign b_fix  = b_diff >= DIVD_W'(DIV_ODD);
            assign b_q    = src_w[2*k+1].qe + CHUNK_W'(b_fix);

            always_comb
            begin
                stg_next[2*k+1]      = src_w[2*k+1];
                stg_next[2*k+1].rem  = b_fix ? REM_W'(b_diff - DIVD_W'(DIV_ODD))
                                             : REM_W'(b_diff);
                stg_next[2*k+1].quot = {src_w[2*k+1].quot[SEC_W-CHUNK_W-1:0], b_q};
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_quot  = stg_reg[STAGES-1].quot;
    assign out_rem   = stg_reg[STAGES-1].rem;
    assign out_side  = stg_reg[STAGES-1].side;

    a_first_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> stg_reg[1].rem < REM_W'(DIV_ODD))
        else $error("partial remainder out of range after first chunk");

    a_last_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_rem < REM_W'(DIV_ODD))
        else $error("final remainder out of range");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("divider refuses input with an empty last stage");

endmodule

`default_nettype wire
